FILE: design/upe_pkg.sv
// Shared types, codes and helper functions of the URI percent encoder.
package upe_pkg;

	localparam int CHAR_W = 16;
	localparam int MASK_W = 3;

	// What one accepted item turns into.
	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_ERR  = 2'd1;
	localparam logic [1:0] KIND_ENC  = 2'd2;

	localparam logic [1:0] POS_PCT = 2'd0;
	localparam logic [1:0] POS_HI  = 2'd1;
	localparam logic [1:0] POS_LO  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_PCT = 16'h0025;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] pass_char;
		logic [3:0][7:0]   utf8;      // utf8[0] is sent first
		logic [1:0]        nbytes_m1;
		logic              eos;
	} item_t;

	// True when the unit passes through unchanged under the given mask.
	function automatic logic in_pass_set(input logic [CHAR_W-1:0] c,
			input logic [MASK_W-1:0] mask);
		logic letter;
		logic rsv;
		letter = (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
		case (c)
			16'h003B, 16'h002F, 16'h003F, 16'h003A, 16'h0040,
			16'h0026, 16'h003D, 16'h002B, 16'h0024, 16'h002C: rsv = 1'b1;
			default: rsv = 1'b0;
		endcase
		return (mask[0] && letter) || (mask[1] && c == 16'h0023) || (mask[2] && rsv);
	endfunction

	// Uppercase hex digit of a nibble, as a 16-bit character.
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
		logic [7:0] ch;
		ch = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
		return {8'd0, ch};
	endfunction

endpackage

FILE: design/uri_percent_encoder_core.sv
// Top level of the URI percent encoder: decode stage, expansion stage and output register.
//
// The block reads one UTF-16 code unit per input item and writes the percent-encoded
// string one character per output item. A unit in the pass set (chosen by the 3-bit
// configuration register: letters, '#', reserved punctuation) comes out unchanged as one
// item. Any other unit, or a high/low surrogate pair, is converted to UTF-8 and comes out
// as '%' plus two uppercase hex digits per byte: 3, 6, 9 or 12 items. A high surrogate is
// held and produces nothing until its partner arrives. A lone low surrogate, or a high
// surrogate not followed by a low one, produces one error item (character 0, error flag
// set) and the rest of the string is dropped up to and including its last unit.
// Rate: the decode is done in the cycle an item is accepted; the expansion stage then
// emits one character per cycle while the output register is free or being read, and
// holds an item until its last result is out. Items with one result or none are accepted
// every cycle while the downstream side takes results; the next item is taken in the same
// cycle that the last character of the current one moves to the output register, so the
// expansion counter sets the throughput. The output register lets input continue while a
// result waits for the downstream side.
module uri_percent_encoder_core
	import upe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MASK_W-1:0] cfg_data,       // pass_set_mask
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [CHAR_W-1:0] s_axis_tdata,   // [15:0] code_unit
	input  logic              s_axis_tlast,   // end_of_string
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [CHAR_W-1:0] m_axis_tdata,   // [15:0] out_char
	output logic              m_axis_tlast,   // last_of_run
	output logic [1:0]        m_axis_tuser    // [0] error_flag, [1] string_done
);

	// Configuration and string state.
	logic [MASK_W-1:0] mask_q;
	logic [9:0]        held_bits_q;
	logic              held_valid_q;
	logic              error_seen_q;

	// Expansion stage.
	logic              valid_s1;
	item_t             item_s1;
	logic [1:0]        byte_q;
	logic [1:0]        pos_q;

	// Output register.
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;
	logic              out_err_q;
	logic              out_done_q;

	logic              accept;
	logic              emit_go;
	logic              emit_last;

	// Decode of the incoming unit.
	logic [CHAR_W-1:0] c;
	logic              is_low;
	logic              is_high;
	logic              pass;
	logic [20:0]       supp;
	item_t             item_d;
	logic              produce;
	logic              err_d;
	logic              hold_d;
	logic [CHAR_W-1:0] char_d;
	logic [7:0]        cur_byte;

	assign cfg_ready = 1'b1;

	assign c       = s_axis_tdata;
	assign is_low  = (c >= 16'hDC00) && (c <= 16'hDFFF);
	assign is_high = (c >= 16'hD800) && (c <= 16'hDBFF);
	assign pass    = in_pass_set(c, mask_q);
	assign supp    = {1'b0, held_bits_q, c[9:0]} + 21'h10000;

	always_comb begin
		item_d           = '0;
		item_d.pass_char = c;
		item_d.eos       = s_axis_tlast;
		produce          = 1'b0;
		err_d            = 1'b0;
		hold_d           = 1'b0;
		if (error_seen_q) begin
			produce = 1'b0;
		end else if (held_valid_q) begin
			if (is_low) begin
				produce          = 1'b1;
				item_d.kind      = KIND_ENC;
				item_d.utf8[0]   = {5'b11110, supp[20:18]};
				item_d.utf8[1]   = {2'b10, supp[17:12]};
				item_d.utf8[2]   = {2'b10, supp[11:6]};
				item_d.utf8[3]   = {2'b10, supp[5:0]};
				item_d.nbytes_m1 = 2'd3;
			end else begin
				err_d = 1'b1;
			end
		end else if (pass) begin
			produce     = 1'b1;
			item_d.kind = KIND_PASS;
		end else if (is_low) begin
			err_d = 1'b1;
		end else if (is_high) begin
			if (s_axis_tlast) begin
				err_d = 1'b1;
			end else begin
				hold_d = 1'b1;
			end
		end else begin
			produce     = 1'b1;
			item_d.kind = KIND_ENC;
			if (c <= 16'h007F) begin
				item_d.utf8[0]   = c[7:0];
				item_d.nbytes_m1 = 2'd0;
			end else if (c <= 16'h07FF) begin
				item_d.utf8[0]   = {3'b110, c[10:6]};
				item_d.utf8[1]   = {2'b10, c[5:0]};
				item_d.nbytes_m1 = 2'd1;
			end else begin
				item_d.utf8[0]   = {4'b1110, c[15:12]};
				item_d.utf8[1]   = {2'b10, c[11:6]};
				item_d.utf8[2]   = {2'b10, c[5:0]};
				item_d.nbytes_m1 = 2'd2;
			end
		end
		if (err_d) begin
			produce     = 1'b1;
			item_d.kind = KIND_ERR;
		end
	end

	// Expansion: one character per cycle out of the held item while the output register can take it.
	assign emit_go   = valid_s1 && (!out_valid_q || m_axis_tready);
	assign emit_last = (item_s1.kind != KIND_ENC) ||
		(byte_q == item_s1.nbytes_m1 && pos_q == POS_LO);
	assign s_axis_tready = !valid_s1 || (emit_go && emit_last);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cur_byte      = item_s1.utf8[byte_q];

	always_comb begin
		case (item_s1.kind)
			KIND_PASS: char_d = item_s1.pass_char;
			KIND_ENC: begin
				case (pos_q)
					POS_PCT: char_d = CHAR_PCT;
					POS_HI:  char_d = hex_char(cur_byte[7:4]);
					default: char_d = hex_char(cur_byte[3:0]);
				endcase
			end
			default:   char_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= MASK_W'(1);
			held_valid_q <= 1'b0;
			error_seen_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (accept) begin
				if (s_axis_tlast) begin
					held_valid_q <= 1'b0;
					error_seen_q <= 1'b0;
				end else begin
					if (!error_seen_q) begin
						held_valid_q <= hold_d;
					end
					if (err_d) begin
						error_seen_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_d) begin
			held_bits_q <= c[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_q   <= '0;
			pos_q    <= POS_PCT;
		end else begin
			if (accept && produce) begin
				valid_s1 <= 1'b1;
			end else if (emit_go && emit_last) begin
				valid_s1 <= 1'b0;
			end
			if (emit_go) begin
				if (emit_last) begin
					byte_q <= '0;
					pos_q  <= POS_PCT;
				end else if (pos_q == POS_LO) begin
					byte_q <= byte_q + 2'd1;
					pos_q  <= POS_PCT;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			item_s1 <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_char_q <= char_d;
			out_last_q <= emit_last;
			out_err_q  <= (item_s1.kind == KIND_ERR);
			out_done_q <= emit_last && item_s1.eos;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_char_q;
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_err_q;
	assign m_axis_tuser[1] = out_done_q;

`ifndef SYNTHESIS
	a_err_item_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tlast)
		else $error("error item must carry character zero and end its run");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("string end flagged on an item that does not end its run");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == POS_PCT || pos_q == POS_HI || pos_q == POS_LO)
		else $error("hex position counter out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled while the expansion stage is empty");

	a_counter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> byte_q == '0 && pos_q == POS_PCT)
		else $error("expansion counters not cleared between items");
`endif

endmodule

FILE: dv/uri_percent_encoder_core_tb.sv
// Self-checking testbench of the URI percent encoder core.
`timescale 1ns / 1ps

module uri_percent_encoder_core_tb;
	import upe_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int RESET_CYC   = 12;
	localparam int SETTLE_CYC  = 30;       // longer than the deepest expansion of one item
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 48;
	localparam int MAX_REPORTS = 10;

	// One expected output character of the encoder.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last_of_run;
		logic              err;
		logic              done;
	} enc_char_t;

	// Predicts the encoded characters of each accepted code unit and checks the
	// characters that come out against them in order.
	class upe_scoreboard;
		bit [MASK_W-1:0] mask;
		bit [9:0]        held_bits;
		bit              held_valid;
		bit              err_seen;
		enc_char_t       pending[$];
		enc_char_t       run[$];
		int              mismatches;
		int              chars_checked;

		function new();
			mask          = 3'd1;
			held_bits     = '0;
			held_valid    = 1'b0;
			err_seen      = 1'b0;
			mismatches    = 0;
			chars_checked = 0;
		endfunction

		function bit passes(bit [CHAR_W-1:0] c);
			bit letter;
			bit rsv;
			letter = c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]};
			rsv = (c[15:8] == 8'h00) &&
				(c[7:0] inside {";", "/", "?", ":", "@", "&", "=", "+", "$", ","});
			return (mask[0] && letter) || (mask[1] && c == 16'h0023) || (mask[2] && rsv);
		endfunction

		function bit [CHAR_W-1:0] nibble_char(bit [3:0] n);
			if (n < 4'd10)
				return 16'h0030 + n;
			return 16'h0041 + (n - 4'd10);
		endfunction

		function void add_char(bit [CHAR_W-1:0] ch, bit err);
			enc_char_t c;
			c.ch          = ch;
			c.last_of_run = 1'b0;
			c.err         = err;
			c.done        = 1'b0;
			run.push_back(c);
		endfunction

		function void add_byte(bit [7:0] b);
			add_char(16'h0025, 1'b0);
			add_char(nibble_char(b[7:4]), 1'b0);
			add_char(nibble_char(b[3:0]), 1'b0);
		endfunction

		// UTF-8 bytes of one scalar value, each as '%' and two hex digits.
		function void encode(bit [20:0] v);
			if (v <= 21'h7F) begin
				add_byte(v[7:0]);
			end else if (v <= 21'h7FF) begin
				add_byte({3'b110, v[10:6]});
				add_byte({2'b10, v[5:0]});
			end else if (v <= 21'hFFFF) begin
				add_byte({4'b1110, v[15:12]});
				add_byte({2'b10, v[11:6]});
				add_byte({2'b10, v[5:0]});
			end else begin
				add_byte({5'b11110, v[20:18]});
				add_byte({2'b10, v[17:12]});
				add_byte({2'b10, v[11:6]});
				add_byte({2'b10, v[5:0]});
			end
		endfunction

		function void note_unit(bit [CHAR_W-1:0] c, bit eos);
			bit        is_low;
			bit        is_high;
			bit        err;
			enc_char_t tail;
			is_low  = (c >= 16'hDC00 && c <= 16'hDFFF);
			is_high = (c >= 16'hD800 && c <= 16'hDBFF);
			err     = 1'b0;
			run.delete();
			if (err_seen) begin
				// The rest of a broken string is dropped.
			end else if (held_valid) begin
				// Whatever follows a high surrogate is consumed, paired or not.
				if (is_low)
					encode({1'b0, held_bits, c[9:0]} + 21'h10000);
				else
					err = 1'b1;
				held_valid = 1'b0;
				held_bits  = '0;
			end else if (passes(c)) begin
				add_char(c, 1'b0);
			end else if (is_low) begin
				err = 1'b1;
			end else if (is_high) begin
				if (eos) begin
					err = 1'b1;
				end else begin
					held_bits  = c[9:0];
					held_valid = 1'b1;
				end
			end else begin
				encode({5'd0, c});
			end
			if (err) begin
				add_char('0, 1'b1);
				err_seen = 1'b1;
			end
			if (run.size() > 0) begin
				tail             = run.pop_back();
				tail.last_of_run = 1'b1;
				tail.done        = eos;
				run.push_back(tail);
			end
			if (eos) begin
				held_valid = 1'b0;
				held_bits  = '0;
				err_seen   = 1'b0;
			end
			foreach (run[i])
				pending.push_back(run[i]);
		endfunction

		function void check_char(logic [CHAR_W-1:0] ch, logic last, logic [1:0] user);
			enc_char_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: character %h last %b user %b with nothing expected",
						ch, last, user);
				return;
			end
			want = pending.pop_front();
			chars_checked++;
			if (ch !== want.ch || last !== want.last_of_run || user[0] !== want.err ||
					user[1] !== want.done) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: got char %h last %b err %b done %b, want %h %b %b %b",
						ch, last, user[0], user[1],
						want.ch, want.last_of_run, want.err, want.done);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MASK_W-1:0] cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [CHAR_W-1:0] s_axis_tdata;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [CHAR_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic [1:0]        m_axis_tuser;

	upe_scoreboard     sb;
	int                tx_idle_pct;
	int                rx_idle_pct;
	int                cycle_count;
	int                units_sent;
	int                strings_sent;
	int                mask_writes;
	logic [CHAR_W-1:0] str_units[$];

	uri_percent_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// Run limit, far above the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still expected",
				cycle_count, sb.pending.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver backpressure, changed at the falling edge only.
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Every handshake is observed at the rising edge, where all inputs are stable.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.mask = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				sb.note_unit(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	// Called right after a falling edge; returns right after one.
	task automatic send_unit(input logic [CHAR_W-1:0] unit, input logic eos);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = unit;
		s_axis_tlast  = eos;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		units_sent++;
	endtask

	task automatic send_string();
		foreach (str_units[i])
			send_unit(str_units[i], i == str_units.size() - 1);
		str_units.delete();
		strings_sent++;
	endtask

	// Waits until every expected character is out and the expansion stage is quiet.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		mask_writes++;
	endtask

	// One non-surrogate unit of a chosen class, or a surrogate pair; with allow_broken also a random or broken sequence.
	task automatic add_random_unit(input bit allow_broken);
		int  pick;
		int  r;
		byte rsv_chars[10];
		rsv_chars = '{";", "/", "?", ":", "@", "&", "=", "+", "$", ","};
		pick = $urandom_range(0, allow_broken ? 99 : 86);
		if (pick < 20) begin
			r = $urandom_range(0, 51);
			str_units.push_back(CHAR_W'(r < 26 ? 16'h0041 + r : 16'h0061 + r - 26));
		end else if (pick < 25) begin
			str_units.push_back(16'h0023);
		end else if (pick < 33) begin
			str_units.push_back({8'h00, rsv_chars[$urandom_range(0, 9)]});
		end else if (pick < 48) begin
			str_units.push_back(CHAR_W'($urandom_range(0, 16'h007F)));
		end else if (pick < 60) begin
			str_units.push_back(CHAR_W'($urandom_range(16'h0080, 16'h07FF)));
		end else if (pick < 72) begin
			if ($urandom_range(0, 1))
				str_units.push_back(CHAR_W'($urandom_range(16'h0800, 16'hD7FF)));
			else
				str_units.push_back(CHAR_W'($urandom_range(16'hE000, 16'hFFFF)));
		end else if (pick < 87) begin
			str_units.push_back(CHAR_W'($urandom_range(16'hD800, 16'hDBFF)));
			str_units.push_back(CHAR_W'($urandom_range(16'hDC00, 16'hDFFF)));
		end else if (pick < 94) begin
			// Any 16-bit value, surrogates included.
			str_units.push_back(CHAR_W'($urandom));
		end else if ($urandom_range(0, 1)) begin
			str_units.push_back(CHAR_W'($urandom_range(16'hDC00, 16'hDFFF)));
		end else begin
			str_units.push_back(CHAR_W'($urandom_range(16'hD800, 16'hDBFF)));
			str_units.push_back(CHAR_W'($urandom_range(0, 16'hD7FF)));
		end
	endtask

	task automatic random_phase(input int tx_pct, input int rx_pct,
			input logic [MASK_W-1:0] mask_value);
		int start_units;
		int len;
		drain();
		write_mask(mask_value);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start_units = units_sent;
		while (units_sent - start_units < PHASE_ITEMS) begin
			len = $urandom_range(1, 6);
			repeat (len) add_random_unit($urandom_range(0, 99) < 25);
			send_string();
			// Now and then the sender holds off until the encoder has emptied.
			if ($urandom_range(0, 9) == 0)
				drain();
		end
	endtask

	initial begin
		sb            = new();
		cycle_count   = 0;
		units_sent    = 0;
		strings_sent  = 0;
		mask_writes   = 0;
		tx_idle_pct   = 17;
		rx_idle_pct   = 52;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: everything passes that can, then the edges of each UTF-8 length.
		write_mask(3'd7);
		str_units = '{16'h0041, 16'h007A, 16'h0023, 16'h003B, 16'h002C, 16'h0030,
			16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
		send_string();
		// Lowest and highest supplementary characters.
		str_units = '{16'hD800, 16'hDC00};
		send_string();
		str_units = '{16'hDBFF, 16'hDFFF};
		send_string();
		// Lone low surrogate; the rest of the string is dropped, the end included.
		str_units = '{16'hDC00, 16'h0042, 16'h0035};
		send_string();
		// High surrogate followed by a passing unit, which is swallowed.
		str_units = '{16'hD801, 16'h002F};
		send_string();
		// High surrogate as the last unit of its string.
		str_units = '{16'hDAAA};
		send_string();
		drain();
		// Empty pass set: letters and punctuation are escaped.
		write_mask(3'd0);
		str_units = '{16'h0061, 16'h0023, 16'h003F};
		send_string();

		random_phase(17, 52, MASK_W'($urandom_range(0, 7)));
		random_phase(52, 17, MASK_W'($urandom_range(0, 7)));
		random_phase(0, 0, 3'd7);
		drain();

		$display("covered %0d code units in %0d strings under %0d pass-set settings",
			units_sent, strings_sent, mask_writes);
		$display("checked %0d output characters, %0d mismatches",
			sb.chars_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
